// ===== src/pwcd_pkg.sv =====
`timescale 1ns / 1ps

package pwcd_pkg;

    localparam int CFG_W          = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int DEF_COUNT_BITS = 8;

    // Command sum is eight bits wide; the widest weight sum per edge is 6.
    localparam int SUM_W = 8;

    localparam logic [CFG_W-1:0] RST_BAND_ONE   = 8'd55;
    localparam logic [CFG_W-1:0] RST_BAND_TWO   = 8'd110;
    localparam logic [CFG_W-1:0] RST_BAND_THREE = 8'd165;
    localparam logic [CFG_W-1:0] RST_RESET_CODE = 8'd11;
    localparam logic [CFG_W-1:0] RST_READY_CODE = 8'd15;
    localparam logic [CFG_W-1:0] RST_GO_CODE    = 8'd13;

    localparam logic [SUM_W:0] WEIGHT_ONE   = 9'd1;
    localparam logic [SUM_W:0] WEIGHT_TWO   = 9'd4;
    localparam logic [SUM_W:0] WEIGHT_THREE = 9'd6;
    localparam logic [SUM_W:0] SUM_MAX      = 9'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BAND_ONE   = 3'd0,
        REG_BAND_TWO   = 3'd1,
        REG_BAND_THREE = 3'd2,
        REG_RESET_CODE = 3'd3,
        REG_READY_CODE = 3'd4,
        REG_GO_CODE    = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_RESET = 2'd0,
        MODE_READY = 2'd1,
        MODE_GO    = 2'd2
    } mode_t;

    typedef struct packed {
        logic [CFG_W-1:0] band_one;
        logic [CFG_W-1:0] band_two;
        logic [CFG_W-1:0] band_three;
        logic [CFG_W-1:0] reset_code;
        logic [CFG_W-1:0] ready_code;
        logic [CFG_W-1:0] go_code;
    } cfg_t;

endpackage

// ===== src/pwcd_cfg.sv =====
`timescale 1ns / 1ps

module pwcd_cfg
    import pwcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_BAND_ONE:   cfg_next.band_one   = wr_data;
                REG_BAND_TWO:   cfg_next.band_two   = wr_data;
                REG_BAND_THREE: cfg_next.band_three = wr_data;
                REG_RESET_CODE: cfg_next.reset_code = wr_data;
                REG_READY_CODE: cfg_next.ready_code = wr_data;
                REG_GO_CODE:    cfg_next.go_code    = wr_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.band_one   <= RST_BAND_ONE;
            cfg_reg.band_two   <= RST_BAND_TWO;
            cfg_reg.band_three <= RST_BAND_THREE;
            cfg_reg.reset_code <= RST_RESET_CODE;
            cfg_reg.ready_code <= RST_READY_CODE;
            cfg_reg.go_code    <= RST_GO_CODE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/pwcd_core.sv =====
`timescale 1ns / 1ps

module pwcd_core
    import pwcd_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step,
    input  logic  level,
    input  cfg_t  cfg,
    output mode_t mode_next,
    output logic  frame_next
);

    localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic                  last_level_reg, last_level_next;
    logic [COUNT_BITS-1:0] tick_count_reg, tick_count_next;
    logic                  counting_reg, counting_next;
    logic                  timeout_seen_reg, timeout_seen_next;
    logic [SUM_W-1:0]      command_sum_reg, command_sum_next;
    mode_t                 mode_reg, mode_upd;

    logic [CMP_W-1:0] t_ext, lim1, lim2, lim3;
    logic             in_one, in_two, in_three;
    logic [SUM_W:0]   sum_wide;
    logic             fall, rise;

    assign t_ext = CMP_W'(tick_count_reg);
    assign lim1  = CMP_W'(cfg.band_one);
    assign lim2  = CMP_W'(cfg.band_two);
    assign lim3  = CMP_W'(cfg.band_three);

    // Bands are bounded by adjacent limits and are mutually exclusive; at most one weight is added.
    assign in_one   = (t_ext != '0) && (t_ext <= lim1);
    assign in_two   = (t_ext > lim1) && (t_ext <= lim2);
    assign in_three = (t_ext > lim2) && (t_ext <= lim3);

    assign sum_wide = {1'b0, command_sum_reg}
                    + (in_one   ? WEIGHT_ONE   : '0)
                    + (in_two   ? WEIGHT_TWO   : '0)
                    + (in_three ? WEIGHT_THREE : '0);

    assign fall = last_level_reg && !level;
    assign rise = !last_level_reg && level;

    always_comb
    begin
        last_level_next   = level;
        tick_count_next   = tick_count_reg;
        counting_next     = counting_reg;
        timeout_seen_next = timeout_seen_reg;
        command_sum_next  = command_sum_reg;
        mode_upd          = mode_reg;
        frame_next        = 1'b0;
        if (fall)
        begin
            if (timeout_seen_reg)
            begin
                timeout_seen_next = 1'b0;
            end
            else
            begin
                tick_count_next = '0;
                counting_next   = 1'b1;
            end
        end
        else if (rise)
        begin
            counting_next    = 1'b0;
            command_sum_next = (sum_wide > SUM_MAX) ? SUM_MAX[SUM_W-1:0]
                                                    : sum_wide[SUM_W-1:0];
        end
        else if (counting_reg)
        begin
            if (tick_count_reg == COUNT_MAX)
            begin
                tick_count_next = '0;
                counting_next   = 1'b0;
                if (command_sum_reg == cfg.reset_code)
                    mode_upd = MODE_RESET;
                else if (command_sum_reg == cfg.ready_code)
                    mode_upd = MODE_READY;
                else if (command_sum_reg == cfg.go_code)
                    mode_upd = MODE_GO;
                command_sum_next  = '0;
                timeout_seen_next = 1'b1;
                frame_next        = 1'b1;
            end
            else
            begin
                tick_count_next = tick_count_reg + COUNT_BITS'(1);
            end
        end
    end

    assign mode_next = mode_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg   <= 1'b1;
            tick_count_reg   <= '0;
            counting_reg     <= 1'b0;
            timeout_seen_reg <= 1'b0;
            command_sum_reg  <= '0;
            mode_reg         <= MODE_RESET;
        end
        else if (step)
        begin
            last_level_reg   <= last_level_next;
            tick_count_reg   <= tick_count_next;
            counting_reg     <= counting_next;
            timeout_seen_reg <= timeout_seen_next;
            command_sum_reg  <= command_sum_next;
            mode_reg         <= mode_upd;
        end
    end

endmodule

// ===== src/pulse_width_command_decoder.sv =====
`timescale 1ns / 1ps
// Path: an accepted request is held in the input register and then moves into
// the result register, from which its result is taken.
// Throughput: one request per cycle unless out_stall backs up; the input and result
// registers each take a new request whenever the stage after them moves.
// Reset (rst_n, asynchronous, active low): both stages empty, registers at
// their defaults, line taken as idle high, counter stopped, reset mode.
module pulse_width_command_decoder
    import pwcd_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data,
    // sample channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 line_level,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 ready_pin,
    output logic                 go_pin,
    output logic                 go_lamp,
    output logic                 reset_lamp,
    output logic [1:0]           start_mode,
    output logic                 frame_end
);

    cfg_t  cfg;
    mode_t mode_next;
    logic  frame_next;

    // Input register: holds one sample request.
    logic s1_valid_reg, s1_valid_next;
    logic s1_level_reg;

    // Result register.
    logic  out_valid_reg, out_valid_next;
    mode_t out_mode_reg;
    logic  out_frame_reg;

    logic advance;
    logic accept;

    // Move the held sample into the result register when that register
    // is empty or its content is taken at this edge.
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    // Take a new sample when the input register is empty or drains now.
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    pwcd_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // Decoder state advances exactly once per sample, as it leaves stage one.
    pwcd_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .level      (s1_level_reg),
        .cfg        (cfg),
        .mode_next  (mode_next),
        .frame_next (frame_next)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_level_reg <= line_level;
        if (advance)
        begin
            out_mode_reg  <= mode_next;
            out_frame_reg <= frame_next;
        end
    end

    // Pin and lamp levels follow straight from the registered mode.
    assign out_valid  = out_valid_reg;
    assign ready_pin  = (out_mode_reg == MODE_READY);
    assign go_pin     = (out_mode_reg == MODE_GO);
    assign go_lamp    = (out_mode_reg == MODE_READY) || (out_mode_reg == MODE_GO);
    assign reset_lamp = (out_mode_reg == MODE_RESET) || (out_mode_reg == MODE_READY);
    assign start_mode = out_mode_reg;
    assign frame_end  = out_frame_reg;

endmodule
